/* src/ctcdec_pkg.sv */
// ctcdec_pkg: types, widths and codes shared by the greedy ctc decoder files.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ctcdec_pkg;

  // field and state widths
  localparam int CLASS_BITS     = 15;
  localparam int SCORE_BITS     = 16;
  localparam int SUM_BITS       = 26;
  localparam int COUNT_BITS     = 11;
  localparam int NC_BITS        = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // limits
  localparam int MAX_CLASSES = 32768;
  localparam int MAX_STEPS   = 1024;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // event queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // serial divider step counter
  localparam int STEP_BITS = 5;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_CLASSES = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DICT_SIZE   = 2'd1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SPACE   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_SYM,
    B_DIV,
    B_SUM
  } back_state_t;

  // one closed timestep as handed from front to back
  typedef struct packed {
    logic                  has_sym;
    kind_t                 sym_kind;
    logic [CLASS_BITS-1:0] symbol;
    logic                  has_sum;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
  } event_t;

endpackage

/* src/ctcdec_in_if.sv */
// ctcdec_in_if: score input channel, valid/ready with score and end_of_line.
// Depends on ctcdec_pkg.
`timescale 1ns / 1ps

interface ctcdec_in_if;
  import ctcdec_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] score;
  logic                  end_of_line;

  modport source (output valid, output score, output end_of_line, input ready);
  modport sink (input valid, input score, input end_of_line, output ready);
endinterface

/* src/ctcdec_out_if.sv */
// ctcdec_out_if: result output channel, valid/ready with the result fields.
// Depends on ctcdec_pkg.
`timescale 1ns / 1ps

interface ctcdec_out_if;
  import ctcdec_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [CLASS_BITS-1:0] symbol;
  logic [SCORE_BITS-1:0] confidence;
  logic [COUNT_BITS-1:0] symbol_count;
  logic                  last_result;

  modport source (output valid, output kind, output symbol, output confidence,
                  output symbol_count, output last_result, input ready);
  modport sink (input valid, input kind, input symbol, input confidence,
                input symbol_count, input last_result, output ready);
endinterface

/* src/ctcdec_cfg_if.sv */
// ctcdec_cfg_if: configuration write channel, valid/ready with index and data.
// Depends on ctcdec_pkg.
`timescale 1ns / 1ps

interface ctcdec_cfg_if;
  import ctcdec_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/greedy_ctc_decoder.sv */
// greedy_ctc_decoder: top level of the greedy ctc decoder.
// Depends on ctcdec_pkg, the three channel interfaces, ctcdec_front,
// ctcdec_queue and ctcdec_back.
`timescale 1ns / 1ps

// Usage
//   scores  : one class score word per cycle, classes in order within a
//             timestep; end_of_line marks the last word of a line. The class
//             position counter, set by num_classes, closes each timestep.
//   results : character and space symbols as timesteps close, then a summary
//             word (kind 2) with the mean score and symbol count at line end.
//             last_result marks the final word caused by one input word.
//   cfg     : register writes, always ready, index 0 num_classes, 1 dict_size.
// Throughput: one score word per cycle while the four-entry event queue has
//   room. The back end takes one event at a time; a summary waits on the
//   bit-serial mean divider (26 steps of one quotient bit).
// Path: the event of a closing word is queued, taken into the back end's
//   event register in B_IDLE and shown in B_SYM; a summary follows B_DIV.
// Stall: while results.ready is low the result word holds, the queue fills
//   and scores.ready drops once it is full; nothing is lost.
// Reset: synchronous rst clears all line state and the queue; num_classes
//   returns to 2 and dict_size to 0.

module greedy_ctc_decoder (
  input  logic         clk,
  input  logic         rst,
  ctcdec_in_if.sink    scores,
  ctcdec_out_if.source results,
  ctcdec_cfg_if.sink   cfg
);
  import ctcdec_pkg::*;

  logic   room;
  logic   empty;
  logic   push;
  logic   pop;
  event_t push_data;
  event_t pop_data;

  // classify scores and close timesteps
  ctcdec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .scores    (scores),
    .cfg       (cfg),
    .room      (room),
    .push      (push),
    .push_data (push_data)
  );

  // decouple front and back
  ctcdec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .room      (room),
    .empty     (empty)
  );

  // produce result words
  ctcdec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .results  (results)
  );

endmodule

/* src/ctcdec_front.sv */
// ctcdec_front: config registers, per-timestep argmax, emit decision and line sums.
// Depends on ctcdec_pkg, ctcdec_in_if, ctcdec_cfg_if.
`timescale 1ns / 1ps

module ctcdec_front (
  input  logic                clk,
  input  logic                rst,
  ctcdec_in_if.sink           scores,
  ctcdec_cfg_if.sink          cfg,
  input  logic                room,
  output logic                push,
  output ctcdec_pkg::event_t  push_data
);
  import ctcdec_pkg::*;

  logic [NC_BITS-1:0]    num_classes;
  logic [CLASS_BITS-1:0] dict_size;

  logic [CLASS_BITS-1:0] class_position;
  logic [SCORE_BITS-1:0] best_score;
  logic [CLASS_BITS-1:0] best_class;
  logic [CLASS_BITS-1:0] previous_class;
  logic                  previous_valid;
  logic [SUM_BITS-1:0]   score_sum;
  logic [COUNT_BITS-1:0] emitted_total;

  logic                  accept;
  logic [NC_BITS-1:0]    nc_eff;
  logic [NC_BITS-1:0]    nc_minus1;
  logic [CLASS_BITS-1:0] last_class;
  logic [SCORE_BITS-1:0] cand_score;
  logic [CLASS_BITS-1:0] cand_class;
  logic                  close;
  logic                  fresh;
  logic                  emit_char;
  logic                  emit_space;
  logic                  emit;
  logic [CLASS_BITS-1:0] char_index;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_next;
  logic [COUNT_BITS-1:0] total_next;

  assign scores.ready = room;
  assign cfg.ready    = 1'b1;
  assign accept       = scores.valid && room;

  // clamp the class count to its usable range
  always_comb begin
    if (num_classes < NC_BITS'(2)) begin
      nc_eff = NC_BITS'(2);
    end else if (num_classes > NC_BITS'(MAX_CLASSES)) begin
      nc_eff = NC_BITS'(MAX_CLASSES);
    end else begin
      nc_eff = num_classes;
    end
    nc_minus1  = nc_eff - NC_BITS'(1);
    last_class = nc_minus1[CLASS_BITS-1:0];
  end

  // running argmax, lowest index wins a tie
  always_comb begin
    if (class_position == '0) begin
      cand_score = scores.score;
      cand_class = '0;
    end else if (scores.score > best_score) begin
      cand_score = scores.score;
      cand_class = class_position;
    end else begin
      cand_score = best_score;
      cand_class = best_class;
    end
  end

  // timestep close and emit decision
  always_comb begin
    close      = scores.end_of_line || (class_position >= last_class);
    char_index = cand_class - CLASS_BITS'(1);
    fresh      = (cand_class != '0) && (!previous_valid || (cand_class != previous_class));
    emit_char  = fresh && (char_index < dict_size);
    emit_space = fresh && !emit_char && (cand_class == last_class);
    emit       = emit_char || emit_space;
  end

  // saturating line sums including this timestep's symbol
  always_comb begin
    sum_wide = {1'b0, score_sum} + {{(SUM_BITS + 1 - SCORE_BITS){1'b0}}, cand_score};
    if (!emit) begin
      sum_next = score_sum;
    end else if (sum_wide[SUM_BITS]) begin
      sum_next = SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_BITS-1:0];
    end
    if (emit && (emitted_total < COUNT_BITS'(MAX_STEPS))) begin
      total_next = emitted_total + COUNT_BITS'(1);
    end else begin
      total_next = emitted_total;
    end
  end

  // event handed to the queue
  always_comb begin
    push               = accept && close && (emit || scores.end_of_line);
    push_data.has_sym  = emit;
    push_data.sym_kind = emit_char ? KIND_CHAR : KIND_SPACE;
    push_data.symbol   = emit_char ? char_index : '0;
    push_data.has_sum  = scores.end_of_line;
    push_data.sum      = sum_next;
    push_data.count    = total_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= NC_BITS'(2);
      dict_size   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NUM_CLASSES: num_classes <= cfg.data;
        CFG_DICT_SIZE:   dict_size   <= cfg.data[CLASS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      class_position <= '0;
      best_score     <= '0;
      best_class     <= '0;
      previous_class <= '0;
      previous_valid <= 1'b0;
      score_sum      <= '0;
      emitted_total  <= '0;
    end else if (accept) begin
      best_score <= cand_score;
      best_class <= cand_class;
      if (close) begin
        class_position <= '0;
        if (scores.end_of_line) begin
          previous_class <= '0;
          previous_valid <= 1'b0;
          score_sum      <= '0;
          emitted_total  <= '0;
        end else begin
          previous_class <= cand_class;
          previous_valid <= 1'b1;
          score_sum      <= sum_next;
          emitted_total  <= total_next;
        end
      end else begin
        class_position <= class_position + CLASS_BITS'(1);
      end
    end
  end

endmodule

/* src/ctcdec_queue.sv */
// ctcdec_queue: short event fifo between the front and the back of the decoder.
// Depends on ctcdec_pkg.
`timescale 1ns / 1ps

module ctcdec_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ctcdec_pkg::event_t  push_data,
  input  logic                pop,
  output ctcdec_pkg::event_t  pop_data,
  output logic                room,
  output logic                empty
);
  import ctcdec_pkg::*;

  event_t                slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  fill;
  logic                  do_push;
  logic                  do_pop;

  assign room     = (fill != QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && room;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + QCNT_BITS'(1);
        2'b01:   fill <= fill - QCNT_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* src/ctcdec_back.sv */
// ctcdec_back: drains events, runs the serial mean divider and drives results.
// Depends on ctcdec_pkg, ctcdec_out_if.
`timescale 1ns / 1ps

module ctcdec_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  ctcdec_pkg::event_t  pop_data,
  output logic                pop,
  ctcdec_out_if.source        results
);
  import ctcdec_pkg::*;

  back_state_t           state;
  back_state_t           state_next;
  event_t                cur;
  logic [SUM_BITS-1:0]   quo;
  logic [COUNT_BITS-1:0] rem;
  logic [STEP_BITS-1:0]  step;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  q_bit;
  logic                  div_done;

  // one restoring division step
  always_comb begin
    rem_shift = {rem, quo[SUM_BITS-1]};
    rem_diff  = rem_shift - {1'b0, cur.count};
    q_bit     = (rem_shift >= {1'b0, cur.count});
    div_done  = (step == STEP_BITS'(SUM_BITS - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = pop_data.has_sym ? B_SYM : B_DIV;
        end
      end
      B_SYM: begin
        if (results.ready) begin
          state_next = cur.has_sum ? B_DIV : B_IDLE;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_SUM;
        end
      end
      B_SUM: begin
        if (results.ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop                  = 1'b0;
    results.valid        = 1'b0;
    results.kind         = cur.sym_kind;
    results.symbol       = cur.symbol;
    results.confidence   = '0;
    results.symbol_count = '0;
    results.last_result  = !cur.has_sum;
    case (state)
      B_IDLE: begin
        pop = !empty;
      end
      B_SYM: begin
        results.valid = 1'b1;
      end
      B_SUM: begin
        results.valid        = 1'b1;
        results.kind         = KIND_SUMMARY;
        results.symbol       = '0;
        results.confidence   = (cur.count == '0) ? '0 : quo[SCORE_BITS-1:0];
        results.symbol_count = cur.count;
        results.last_result  = 1'b1;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // event word and divider datapath
  always_ff @(posedge clk) begin
    if (state == B_IDLE && !empty) begin
      cur  <= pop_data;
      quo  <= pop_data.sum;
      rem  <= '0;
      step <= '0;
    end else if (state == B_DIV) begin
      quo  <= {quo[SUM_BITS-2:0], q_bit};
      rem  <= q_bit ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
      step <= step + STEP_BITS'(1);
    end
  end

endmodule

/* bench/greedy_ctc_decoder_tb.sv */
// greedy_ctc_decoder_tb: self-checking bench for the greedy ctc decoder, with
// directed and random score streams, register writes and output stalls.
// Depends on ctcdec_pkg, the three channel interfaces and greedy_ctc_decoder.
`timescale 1ns / 1ps

module greedy_ctc_decoder_tb;
  import ctcdec_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int MAX_REPORTS   = 30;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  // receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  // one result word as the decoder should present it
  typedef struct packed {
    kind_t                 kind;
    logic [CLASS_BITS-1:0] symbol;
    logic [SCORE_BITS-1:0] confidence;
    logic [COUNT_BITS-1:0] symbol_count;
    logic                  last_result;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctcdec_in_if  scores ();
  ctcdec_out_if results ();
  ctcdec_cfg_if cfg ();

  greedy_ctc_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .scores  (scores),
    .results (results),
    .cfg     (cfg)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the decoder registers and line state
  logic [NC_BITS-1:0]    num_classes_reg;
  logic [CLASS_BITS-1:0] dict_size_reg;
  int unsigned           class_pos;
  int unsigned           best_class;
  int unsigned           prev_class;
  logic [SCORE_BITS-1:0] best_score;
  bit                    prev_valid;
  longint unsigned       line_sum;
  int unsigned           line_count;

  result_t         expected_q[$];
  logic [SCORE_BITS-1:0] step_words[$];

  // run statistics
  int error_count  = 0;
  int words_sent   = 0;
  int lines_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;

  // sender and receiver pacing
  bit       sender_gaps = 1'b1;
  int       burst_left  = 0;
  rx_mode_t rx_mode     = RX_RANDOM;
  int       hold_left   = 0;
  int       rx_phase    = 0;

  result_t seen_word;
  result_t due_word;

  function automatic int unsigned class_count(input logic [NC_BITS-1:0] n);
    if (n < 2) return 2;
    if (n > MAX_CLASSES) return MAX_CLASSES;
    return int'(n);
  endfunction

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display({"error at %0t: %s: got kind %0d sym %0d conf %0d cnt %0d last %0b,",
                " want kind %0d sym %0d conf %0d cnt %0d last %0b"},
               $time, what, got.kind, got.symbol, got.confidence, got.symbol_count,
               got.last_result, want.kind, want.symbol, want.confidence,
               want.symbol_count, want.last_result);
  endtask

  // argmax per timestep, symbol mapping and line summary for one score word
  task automatic decode_score(input logic [SCORE_BITS-1:0] value, input logic eol);
    int unsigned last_class;
    int unsigned winner;
    result_t     due [2];
    int          n;
    int          i;
    bit          hit;
    n = 0;
    hit = 1'b0;
    last_class = class_count(num_classes_reg) - 1;
    if (class_pos == 0) begin
      best_score = value;
      best_class = 0;
    end else if (value > best_score) begin
      best_score = value;
      best_class = class_pos;
    end
    if (eol || class_pos >= last_class) begin
      winner = best_class;
      if (winner != 0 && (!prev_valid || winner != prev_class)) begin
        due[0] = '0;
        if (winner - 1 < dict_size_reg) begin
          due[0].kind = KIND_CHAR;
          due[0].symbol = CLASS_BITS'(winner - 1);
          hit = 1'b1;
        end else if (winner == last_class) begin
          due[0].kind = KIND_SPACE;
          hit = 1'b1;
        end
        if (hit) begin
          n = 1;
          line_sum += best_score;
          if (line_sum > SUM_MAX) line_sum = SUM_MAX;
          if (line_count < MAX_STEPS) line_count++;
        end
      end
      prev_class = winner;
      prev_valid = 1'b1;
      class_pos = 0;
      // end of line: mean of emitted scores, then clear the line
      if (eol) begin
        due[n] = '0;
        due[n].kind = KIND_SUMMARY;
        due[n].confidence = (line_count != 0) ? SCORE_BITS'(line_sum / line_count) : '0;
        due[n].symbol_count = COUNT_BITS'(line_count);
        n++;
        prev_valid = 1'b0;
        prev_class = 0;
        line_sum = 0;
        line_count = 0;
      end
    end else begin
      class_pos++;
    end
    if (n > 0) due[n-1].last_result = 1'b1;
    for (i = 0; i < n; i++) expected_q = {expected_q, due[i]};
  endtask

  // offer one score word; with sender_gaps set, bursts are separated by random gaps
  task automatic send_score(input logic [SCORE_BITS-1:0] value, input logic eol);
    int gap;
    if (sender_gaps && burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        scores.valid <= 1'b0;
      end
    end
    @(negedge clk);
    scores.valid <= 1'b1;
    scores.score <= value;
    scores.end_of_line <= eol;
    @(posedge clk);
    while (!scores.ready) @(posedge clk);
    burst_left--;
    words_sent++;
    if (eol) lines_sent++;
    decode_score(value, eol);
  endtask

  // send the queued words, end_of_line on the final one if asked
  task automatic send_words(input bit eol_last);
    int i;
    for (i = 0; i < step_words.size(); i++)
      send_score(step_words[i], eol_last && (i == step_words.size() - 1));
    step_words.delete();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (index)
      CFG_NUM_CLASSES: num_classes_reg = value;
      CFG_DICT_SIZE:   dict_size_reg = value[CLASS_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // stop offering, wait for every expected word, then let the back end settle
  task automatic wait_idle();
    @(negedge clk);
    scores.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset defaults: two classes and no dictionary, so class 1 is a space
  task automatic test_reset_defaults();
    step_words = '{16'd100, 16'd200, 16'd5, 16'd5, 16'd0, 16'd9};
    send_words(1'b1);
    wait_idle();
  endtask

  task automatic test_directed_edges();
    write_reg(CFG_NUM_CLASSES, 16'd5);
    write_reg(CFG_DICT_SIZE, 16'd3);
    // full-scale peak on class 3 gives character 2
    step_words = '{16'd10, 16'd20, 16'd30, 16'hFFFF, 16'd40};
    send_words(1'b0);
    // same winner again emits nothing
    step_words = '{16'd0, 16'd0, 16'd0, 16'd900, 16'd0};
    send_words(1'b0);
    // blank wins
    step_words = '{16'd500, 16'd100, 16'd100, 16'd100, 16'd100};
    send_words(1'b0);
    // tie between classes 2 and 3 goes to the lower index
    step_words = '{16'd7, 16'd7, 16'd9, 16'd9, 16'd3};
    send_words(1'b0);
    // top class outside the dictionary is a space, line closes
    step_words = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
    send_words(1'b1);
    wait_idle();
    // dictionary reaching the top class maps it to a character
    write_reg(CFG_DICT_SIZE, 16'd4);
    step_words = '{16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF};
    send_words(1'b1);
    wait_idle();
    // winner past the dictionary but below the top class: empty summary
    write_reg(CFG_NUM_CLASSES, 16'd6);
    write_reg(CFG_DICT_SIZE, 16'd2);
    step_words = '{16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0};
    send_words(1'b1);
    // early end of line closes the partial timestep
    step_words = '{16'd3, 16'h7FFF};
    send_words(1'b1);
    // lone end of line
    step_words = '{16'd0};
    send_words(1'b1);
    wait_idle();
  endtask

  task automatic test_mid_timestep_config();
    write_reg(CFG_NUM_CLASSES, 16'd6);
    write_reg(CFG_DICT_SIZE, 16'h8005);
    step_words = '{16'd1, 16'd60000, 16'd3, 16'd4};
    send_words(1'b0);
    wait_idle();
    // shrink the class count under the current position: next word closes
    write_reg(CFG_NUM_CLASSES, 16'd3);
    write_reg(CFG_UNUSED, 16'hFFFF);
    step_words = '{16'd2};
    send_words(1'b0);
    step_words = '{16'd0, 16'd0, 16'd50};
    send_words(1'b1);
    wait_idle();
  endtask

  task automatic test_class_count_limits();
    // counts of 0 and 1 act as 2
    write_reg(CFG_DICT_SIZE, 16'd0);
    write_reg(CFG_NUM_CLASSES, 16'd0);
    step_words = '{16'd1, 16'd2, 16'd3, 16'd1};
    send_words(1'b1);
    wait_idle();
    write_reg(CFG_NUM_CLASSES, 16'd1);
    step_words = '{16'd0, 16'hFFFF};
    send_words(1'b1);
    wait_idle();
    // count above the limit is clamped; a short line that ends early
    write_reg(CFG_NUM_CLASSES, 16'hFFFF);
    write_reg(CFG_DICT_SIZE, 16'h7FFF);
    step_words = '{16'd0, 16'd9, 16'hFFFF, 16'd3};
    send_words(1'b1);
    wait_idle();
  endtask

  // long line of full-scale symbols builds up the sum and count
  task automatic test_long_line();
    int i;
    write_reg(CFG_NUM_CLASSES, 16'd3);
    write_reg(CFG_DICT_SIZE, 16'd1);
    sender_gaps = 1'b0;
    for (i = 0; i < 30; i++) begin
      if (i % 2 == 0) step_words = '{16'd0, 16'hFFFF, 16'd0};
      else step_words = '{16'd0, 16'd0, 16'hFFFF};
      send_words(i == 29);
    end
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  // receiver holds off while every timestep emits, so the input stalls
  task automatic test_backpressure();
    int i;
    write_reg(CFG_NUM_CLASSES, 16'd3);
    write_reg(CFG_DICT_SIZE, 16'd1);
    sender_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_left = 300;
    for (i = 0; i < 40; i++) begin
      if (i % 2 == 0) step_words = '{16'd0, 16'($urandom_range(1, 16'hFFFF)), 16'd0};
      else step_words = '{16'd0, 16'd0, 16'($urandom_range(1, 16'hFFFF))};
      send_words(i == 39);
    end
    // sender pauses until all results are out
    wait_idle();
    sender_gaps = 1'b1;
    rx_mode = RX_RANDOM;
  endtask

  task automatic test_random_lines();
    int unsigned start;
    int unsigned n_eff;
    int unsigned total;
    int unsigned cut;
    int unsigned k;
    int unsigned cls;
    int unsigned peak;
    int          ts_mode;
    logic [NC_BITS-1:0]       nc_value;
    logic [CFG_DATA_BITS-1:0] dict_value;
    logic [SCORE_BITS-1:0]    value;
    logic [SCORE_BITS-1:0]    level;
    start = words_sent;
    peak = 1;
    level = '0;
    ts_mode = 0;
    while (words_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      // pick a class count, mostly small
      case ($urandom_range(0, 7))
        0: nc_value = 16'd2;
        1: nc_value = 16'($urandom_range(0, 1));
        2: nc_value = 16'($urandom_range(9, 24));
        default: nc_value = 16'($urandom_range(3, 8));
      endcase
      n_eff = class_count(nc_value);
      case ($urandom_range(0, 4))
        0: dict_value = 16'd0;
        1: dict_value = 16'(n_eff - 1);
        2: dict_value = 16'(n_eff - 2);
        3: dict_value = 16'($urandom_range(n_eff, 32767));
        default: dict_value = 16'($urandom_range(0, n_eff));
      endcase
      dict_value[CFG_DATA_BITS-1] = 1'($urandom_range(0, 1));
      write_reg(CFG_NUM_CLASSES, nc_value);
      write_reg(CFG_DICT_SIZE, dict_value);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      sender_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        total = $urandom_range(1, 4) * n_eff;
        // most lines are whole timesteps, some end early
        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, total) : total;
        for (k = 0; k < cut; k++) begin
          cls = k % n_eff;
          if (cls == 0) begin
            ts_mode = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0) peak = $urandom_range(0, n_eff - 1);
            case ($urandom_range(0, 2))
              0: level = 16'd0;
              1: level = 16'hFFFF;
              default: level = 16'($urandom);
            endcase
          end
          case (ts_mode)
            0: value = 16'($urandom);
            3: value = level;
            default: value = (cls == peak) ? 16'($urandom_range(16'h4000, 16'hFFFF))
                                           : 16'($urandom_range(0, 16'h3FFF));
          endcase
          send_score(value, k == cut - 1);
        end
      end
    end
    wait_idle();
  endtask

  // receiver ready, with a long hold-off on request
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: results.ready <= 1'b1;
          RX_RANDOM: results.ready <= ($urandom_range(0, 9) >= 3);
          default: begin
            rx_phase = (rx_phase + 1) % 5;
            results.ready <= (rx_phase < 3);
          end
        endcase
      end
    end
  end

  // check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      seen_word.kind = kind_t'(results.kind);
      seen_word.symbol = results.symbol;
      seen_word.confidence = results.confidence;
      seen_word.symbol_count = results.symbol_count;
      seen_word.last_result = results.last_result;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("no result expected", seen_word, '0);
      end else begin
        due_word = expected_q.pop_front();
        if (seen_word.kind !== due_word.kind || seen_word.symbol !== due_word.symbol ||
            seen_word.confidence !== due_word.confidence ||
            seen_word.symbol_count !== due_word.symbol_count ||
            seen_word.last_result !== due_word.last_result)
          report_mismatch("wrong result", seen_word, due_word);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (scores.valid && scores.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("greedy_ctc_decoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    scores.valid = 1'b0;
    scores.score = '0;
    scores.end_of_line = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_NUM_CLASSES;
    cfg.data = '0;
    num_classes_reg = 16'd2;
    dict_size_reg = '0;
    class_pos = 0;
    best_class = 0;
    prev_class = 0;
    best_score = '0;
    prev_valid = 1'b0;
    line_sum = 0;
    line_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_edges();
    test_mid_timestep_config();
    test_class_count_limits();
    test_long_line();
    test_backpressure();
    test_random_lines();
    wait_idle();

    $display("ran %0d score words in %0d lines, %0d result words, %0d register writes",
             words_sent, lines_sent, results_seen, cfg_writes);
    $display("covered ties, dictionary and space mapping, early line ends, clamped counts, stalls");
    if (error_count == 0) begin
      $display("greedy_ctc_decoder: match");
    end else begin
      $display("greedy_ctc_decoder: mismatch");
    end
    $finish;
  end

endmodule
